@@ hdl/rmst_pkg.sv @@
// Shared constants, types and helper functions of the range maximum sparse table unit.
`default_nettype none

package rmst_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned LEVELS       = 11;
  localparam int unsigned VALUE_WIDTH  = 64;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned IDX_W     = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned LVL_W     = $clog2(LEVELS);
  localparam int unsigned ADDR_W    = LVL_W + IDX_W;
  localparam int unsigned RAM_DEPTH = LEVELS * MAX_ELEMENTS;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [VALUE_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic  busy;
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  wr_en;
    addr_t wr_addr;
    logic  done;
  } bld_ctl_t;

  typedef struct packed {
    logic  err;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
  } qry_ctl_t;

  // Table address: level in the upper bits, position in the lower bits.
  function automatic addr_t mk_addr(logic [LVL_W-1:0] lvl, logic [IDX_W-1:0] idx);
    return {lvl, idx};
  endfunction

  function automatic elem_t signed_max(elem_t a, elem_t b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  // Sign-extend a stored element to the full output word.
  function automatic logic [DATA_W-1:0] widen(elem_t v);
    logic [DATA_W-1:0] r;
    for (int i = 0; i < DATA_W; i++) begin
      r[i] = (i < VALUE_WIDTH) ? v[i] : v[VALUE_WIDTH-1];
    end
    return r;
  endfunction

  // Floor log2 of a nonzero length, clamped to the top table level.
  function automatic logic [LVL_W-1:0] floor_log2(logic [CNT_W-1:0] len);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (len[i]) begin
        k = LVL_W'(i);
      end
    end
    if (k > LVL_W'(LEVELS - 1)) begin
      k = LVL_W'(LEVELS - 1);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rmst_in_if.sv @@
// Input channel: valid/ready handshake carrying load and query words.
`default_nettype none

interface rmst_in_if;
  import rmst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic [POS_W-1:0]         left;
  logic [POS_W-1:0]         right;

  modport source (output valid, cmd, value, last, left, right, input ready);
  modport sink   (input valid, cmd, value, last, left, right, output ready);
endinterface

`default_nettype wire

@@ hdl/rmst_out_if.sv @@
// Output channel: valid/ready handshake carrying query result words.
`default_nettype none

interface rmst_out_if;
  import rmst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] maximum;
  logic                     error;

  modport source (output valid, maximum, error, input ready);
  modport sink   (input valid, maximum, error, output ready);
endinterface

`default_nettype wire

@@ hdl/range_maximum_sparse_table_unit.sv @@
// Range maximum query unit built on a sparse table held in a dual-read RAM.
// Load word: taken back to back while no build runs. Query word: the RAM read is
// registered on acceptance, then the result moves into the output register once that
// is free; input ready stays low while a query waits in the read stage, and one query
// may wait in flight while a result is held. The build after the last load walks
// the levels through the single RAM write port; no word is taken during the build.
// Reset clears count, ready flag and handshake state; table contents stay undefined.
`default_nettype none

module range_maximum_sparse_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmst_in_if.sink    in_i,
  rmst_out_if.source out_o
);
  import rmst_pkg::*;

  // loaded element count and build-complete flag
  logic [CNT_W-1:0]  count_q, count_d;
  logic              table_ready_q, table_ready_d;

  // query in flight: RAM read issued, data arrives next cycle
  logic              s1_valid_q, s1_valid_d;
  logic              s1_err_q, s1_err_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_maximum_q, out_maximum_d;
  logic              out_error_q, out_error_d;

  logic              in_ready_w;
  logic              accept_w;
  logic              load_acc_w;
  logic              qry_acc_w;
  logic [CNT_W-1:0]  count_base_w;
  logic              has_room_w;
  logic [CNT_W-1:0]  count_new_w;
  logic              out_free_w;

  bld_ctl_t          bld_w;
  qry_ctl_t          qry_w;

  logic              ram_we_w;
  addr_t             ram_waddr_w;
  elem_t             ram_wdata_w;
  logic              ram_re_w;
  addr_t             ram_raddr_a_w;
  addr_t             ram_raddr_b_w;
  elem_t             ram_rdata_a_w;
  elem_t             ram_rdata_b_w;
  elem_t             max_w;

  // Take a word only when no build runs and no query is waiting in the read stage.
  assign in_ready_w = !bld_w.busy && !s1_valid_q;
  assign in_i.ready = in_ready_w;
  assign accept_w   = in_i.valid && in_ready_w;
  assign load_acc_w = accept_w && (in_i.cmd == CMD_LOAD);
  assign qry_acc_w  = accept_w && (in_i.cmd == CMD_QUERY);

  // A load after a finished build starts a fresh data set; drop values past capacity.
  always_comb begin
    count_base_w = table_ready_q ? '0 : count_q;
    has_room_w   = count_base_w < CNT_W'(MAX_ELEMENTS);
    count_new_w  = has_room_w ? count_base_w + CNT_W'(1) : count_base_w;
  end

  rmst_build u_build (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_acc_w && in_i.last),
    .count_i (count_new_w),
    .ctl_o   (bld_w)
  );

  rmst_query u_query (
    .left_i        (in_i.left),
    .right_i       (in_i.right),
    .count_i       (count_q),
    .table_ready_i (table_ready_q),
    .ctl_o         (qry_w)
  );

  // One comparator serves both the build write-back and the query result.
  assign max_w = signed_max(ram_rdata_a_w, ram_rdata_b_w);

  // Write port: build write-back, else level-0 load.
  always_comb begin
    if (bld_w.wr_en) begin
      ram_we_w    = 1'b1;
      ram_waddr_w = bld_w.wr_addr;
      ram_wdata_w = max_w;
    end else begin
      ram_we_w    = load_acc_w && has_room_w;
      ram_waddr_w = mk_addr('0, count_base_w[IDX_W-1:0]);
      ram_wdata_w = in_i.value[VALUE_WIDTH-1:0];
    end
  end

  // Read ports: build sequencer while busy, else the accepted query.
  always_comb begin
    ram_re_w      = bld_w.rd_en || qry_acc_w;
    ram_raddr_a_w = bld_w.rd_en ? bld_w.rd_addr_a : qry_w.rd_addr_a;
    ram_raddr_b_w = bld_w.rd_en ? bld_w.rd_addr_b : qry_w.rd_addr_b;
  end

  rmst_ram #(
    .WIDTH  (VALUE_WIDTH),
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we_w),
    .waddr_i   (ram_waddr_w),
    .wdata_i   (ram_wdata_w),
    .re_i      (ram_re_w),
    .raddr_a_i (ram_raddr_a_w),
    .raddr_b_i (ram_raddr_b_w),
    .rdata_a_o (ram_rdata_a_w),
    .rdata_b_o (ram_rdata_b_w)
  );

  always_comb begin
    count_d       = load_acc_w ? count_new_w : count_q;
    table_ready_d = table_ready_q;
    if (load_acc_w) begin
      table_ready_d = 1'b0;
    end
    // a build that finishes (or has no level to fill) marks the table usable
    if (bld_w.done) begin
      table_ready_d = 1'b1;
    end
  end

  assign out_free_w = !out_valid_q || out_o.ready;

  always_comb begin
    s1_valid_d    = s1_valid_q;
    s1_err_d      = s1_err_q;
    out_valid_d   = out_valid_q;
    out_maximum_d = out_maximum_q;
    out_error_d   = out_error_q;

    if (qry_acc_w) begin
      s1_valid_d = 1'b1;
      s1_err_d   = qry_w.err;
    end

    // advance the finished query into the output register, else drop a taken word
    if (s1_valid_q && out_free_w) begin
      s1_valid_d    = 1'b0;
      out_valid_d   = 1'b1;
      out_maximum_d = s1_err_q ? '0 : widen(max_w);
      out_error_d   = s1_err_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      table_ready_q <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      count_q       <= count_d;
      table_ready_q <= table_ready_d;
      s1_valid_q    <= s1_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_err_q      <= s1_err_d;
    out_maximum_q <= out_maximum_d;
    out_error_q   <= out_error_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.maximum = out_maximum_q;
  assign out_o.error   = out_error_q;

endmodule

`default_nettype wire

@@ hdl/rmst_ram.sv @@
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module rmst_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ hdl/rmst_query.sv @@
// Query decode: range check, window level and the two table addresses.
`default_nettype none

module rmst_query (
  input  logic [rmst_pkg::POS_W-1:0] left_i,
  input  logic [rmst_pkg::POS_W-1:0] right_i,
  input  logic [rmst_pkg::CNT_W-1:0] count_i,
  input  logic                       table_ready_i,
  output rmst_pkg::qry_ctl_t         ctl_o
);
  import rmst_pkg::*;

  logic [CNT_W-1:0] left_w;
  logic [CNT_W-1:0] right_w;
  logic [CNT_W-1:0] len_w;
  logic [CNT_W-1:0] second_w;
  logic [LVL_W-1:0] lvl_w;

  always_comb begin
    left_w   = CNT_W'(left_i);
    right_w  = CNT_W'(right_i);
    len_w    = right_w - left_w + CNT_W'(1);
    lvl_w    = floor_log2(len_w);
    // second window ends at right
    second_w = right_w + CNT_W'(1) - (CNT_W'(1) << lvl_w);

    ctl_o.err       = !table_ready_i || (left_w > right_w) || (right_w >= count_i);
    ctl_o.rd_addr_a = mk_addr(lvl_w, left_w[IDX_W-1:0]);
    ctl_o.rd_addr_b = mk_addr(lvl_w, second_w[IDX_W-1:0]);
  end

endmodule

`default_nettype wire

@@ hdl/rmst_build.sv @@
// Table build sequencer: walks each level, reading two windows and writing their maximum.
`default_nettype none

module rmst_build (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rmst_pkg::CNT_W-1:0] count_i,
  output rmst_pkg::bld_ctl_t         ctl_o
);
  import rmst_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_GAP  = 3'b100
  } bld_state_e;

  bld_state_e       state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             wr_pend_q, wr_pend_d;
  addr_t            wr_addr_q, wr_addr_d;

  logic [CNT_W-1:0] span_w;
  logic [IDX_W-1:0] half_w;
  logic [LVL_W-1:0] lvl_prev_w;
  logic             last_pos_w;
  logic             next_ok_w;
  logic             start_ok_w;

  always_comb begin
    span_w     = CNT_W'(1) << lvl_q;
    half_w     = IDX_W'(span_w >> 1);
    lvl_prev_w = lvl_q - LVL_W'(1);
    last_pos_w = (CNT_W'(pos_q) + span_w) == n_q;
    next_ok_w  = ((CNT_W'(lvl_q) + CNT_W'(1)) < CNT_W'(LEVELS)) && ((span_w << 1) <= n_q);
    start_ok_w = count_i >= CNT_W'(2);
  end

  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    pos_d     = pos_q;
    n_d       = n_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    unique case (state_q)
      B_IDLE: begin
        if (start_i && start_ok_w) begin
          state_d = B_READ;
          lvl_d   = LVL_W'(1);
          pos_d   = '0;
          n_d     = count_i;
        end
      end
      B_READ: begin
        wr_pend_d = 1'b1;
        wr_addr_d = mk_addr(lvl_q, pos_q);
        if (last_pos_w) begin
          state_d = B_GAP;
        end else begin
          pos_d = pos_q + IDX_W'(1);
        end
      end
      B_GAP: begin
        // let the last write of the level land before reading it back
        if (next_ok_w) begin
          state_d = B_READ;
          lvl_d   = lvl_q + LVL_W'(1);
          pos_d   = '0;
        end else begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o.busy      = state_q != B_IDLE;
    ctl_o.rd_en     = state_q == B_READ;
    ctl_o.rd_addr_a = mk_addr(lvl_prev_w, pos_q);
    ctl_o.rd_addr_b = mk_addr(lvl_prev_w, pos_q + half_w);
    ctl_o.wr_en     = wr_pend_q;
    ctl_o.wr_addr   = wr_addr_q;
    ctl_o.done      = ((state_q == B_IDLE) && start_i && !start_ok_w) ||
                      ((state_q == B_GAP) && !next_ok_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    pos_q     <= pos_d;
    n_q       <= n_d;
    wr_addr_q <= wr_addr_d;
  end

endmodule

`default_nettype wire

@@ hdl/rmst_checker.sv @@
// Port-level checks of the range maximum sparse table unit, bound to the top level.
`default_nettype none

module rmst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_cmd_i,
  input logic                        in_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rmst_pkg::DATA_W-1:0] out_maximum_i,
  input logic                        out_error_i
);
  import rmst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> out_maximum_i == '0)
    else $error("error result carries a nonzero maximum");

  a_query_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CMD_QUERY) && !out_valid_i |-> ##2 out_valid_i)
    else $error("query result missing two cycles after an empty output");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CMD_LOAD) && !in_last_i |=> in_ready_i)
    else $error("input stalled after a plain load");

endmodule

bind range_maximum_sparse_table_unit rmst_checker u_rmst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_cmd_i      (in_i.cmd),
  .in_last_i     (in_i.last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_maximum_i (out_o.maximum),
  .out_error_i   (out_o.error)
);

`default_nettype wire

@@ tb/range_maximum_sparse_table_unit_checker.sv @@
// Channel monitor: sparse table predictor and result comparison for the range maximum unit.
`timescale 1ns / 100ps

module range_maximum_sparse_table_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmst_in_if          in_i,
  rmst_out_if         out_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned flagged_o,
  output int unsigned loads_o,
  output int unsigned builds_o
);
  import rmst_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] maximum;
    logic                     error;
  } answer_t;

  // Own copy of the block state: level 0 holds the loaded values.
  logic signed [DATA_W-1:0] window_max [LEVELS][MAX_ELEMENTS];
  int unsigned              loaded_count = 0;
  bit                       table_built  = 1'b0;

  answer_t     expected_answers [$];
  int unsigned mismatches = 0;
  int unsigned waiting    = 0;
  int unsigned results    = 0;
  int unsigned flagged    = 0;
  int unsigned loads      = 0;
  int unsigned builds     = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = waiting;
  assign results_o        = results;
  assign flagged_o        = flagged;
  assign loads_o          = loads;
  assign builds_o         = builds;

  function automatic logic signed [DATA_W-1:0] larger_of(logic signed [DATA_W-1:0] a,
                                                          logic signed [DATA_W-1:0] b);
    return (a >= b) ? a : b;
  endfunction

  always @(posedge clk_i) begin : watch_channels
    answer_t     want;
    answer_t     due;
    int unsigned lo;
    int unsigned hi;
    int unsigned len;
    int unsigned tail;
    int          lvl;
    if (rst_ni) begin
      // Check the result first: a query accepted on this edge cannot answer yet.
      if (out_i.valid && out_i.ready) begin
        results++;
        if (expected_answers.size() == 0) begin
          $display("%0t: result with nothing expected: maximum %0d error %0b",
                   $time, out_i.maximum, out_i.error);
          mismatches++;
        end else begin
          due = expected_answers.pop_front();
          waiting--;
          if (due.error) flagged++;
          if (out_i.maximum !== due.maximum) begin
            $display("%0t: maximum mismatch: expected %0d, actual %0d",
                     $time, due.maximum, out_i.maximum);
            mismatches++;
          end
          if (out_i.error !== due.error) begin
            $display("%0t: error flag mismatch: expected %0b, actual %0b",
                     $time, due.error, out_i.error);
            mismatches++;
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        if (in_i.cmd == CMD_LOAD) begin
          loads++;
          // A load after a build starts a fresh data set.
          if (table_built) begin
            table_built  = 1'b0;
            loaded_count = 0;
          end
          // Drop the value once the store is full.
          if (loaded_count < MAX_ELEMENTS) begin
            window_max[0][loaded_count] = $signed(in_i.value[VALUE_WIDTH-1:0]);
            loaded_count++;
          end
          if (in_i.last) begin
            for (lvl = 1; lvl < LEVELS && (1 << lvl) <= loaded_count; lvl++) begin
              for (int j = 0; j + (1 << lvl) <= loaded_count; j++) begin
                window_max[lvl][j] = larger_of(window_max[lvl-1][j],
                                               window_max[lvl-1][j + (1 << (lvl - 1))]);
              end
            end
            table_built = 1'b1;
            builds++;
          end
        end else begin
          want.maximum = '0;
          want.error   = 1'b1;
          lo = in_i.left;
          hi = in_i.right;
          if (table_built && lo <= hi && hi < loaded_count) begin
            len = hi - lo + 1;
            lvl = 0;
            while (lvl + 1 < LEVELS && (len >> (lvl + 1)) != 0) lvl++;
            tail = hi + 1 - (1 << lvl);
            want.maximum = larger_of(window_max[lvl][lo], window_max[lvl][tail]);
            want.error   = 1'b0;
          end
          expected_answers.push_back(want);
          waiting++;
        end
      end
    end
  end

endmodule

@@ tb/range_maximum_sparse_table_unit_tb.sv @@
// Top of the range maximum unit testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module range_maximum_sparse_table_unit_tb;
  import rmst_pkg::*;

  localparam int unsigned GAP_PERCENT    = 15;
  localparam int unsigned HOLD_CYCLES    = 300;    // long receiver hold-off
  localparam int unsigned IDLE_LIMIT     = 60000;  // outlasts the quiet time of a full-size build
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned RANDOM_ITEMS   = 250;
  localparam int unsigned PRESSURE_LOADS = 96;

  localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Shared pacing controls: steady turns off idling on both sides, hold_request
  // asks the receiver for its one long hold-off.
  bit steady       = 1'b0;
  bit hold_request = 1'b0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned flagged;
  int unsigned loads;
  int unsigned builds;
  int unsigned quiet_cycles = 0;

  rmst_in_if  in_ch ();
  rmst_out_if out_ch ();

  range_maximum_sparse_table_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  range_maximum_sparse_table_unit_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_ch),
    .out_i            (out_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .results_o        (results),
    .flagged_o        (flagged),
    .loads_o          (loads),
    .builds_o         (builds)
  );

  always #4 clk_i = ~clk_i;

  // Offer one word at the falling edge, after an optional random gap, and hold
  // it until the block takes it. Return at the falling edge after acceptance.
  task automatic push_word(logic cmd, logic signed [DATA_W-1:0] value, logic last,
                           logic [POS_W-1:0] left, logic [POS_W-1:0] right);
    while (!steady && $urandom_range(99) < GAP_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    in_ch.last  <= last;
    in_ch.left  <= left;
    in_ch.right <= right;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Load word: scramble the range fields, which the block must ignore.
  task automatic load_value(logic signed [DATA_W-1:0] value, logic last);
    push_word(CMD_LOAD, value, last, POS_W'($urandom), POS_W'($urandom));
  endtask

  // Query word: scramble value and last, which the block must ignore.
  task automatic ask_range(int unsigned left, int unsigned right);
    push_word(CMD_QUERY, {$urandom, $urandom}, 1'($urandom), POS_W'(left), POS_W'(right));
  endtask

  // Mix extremes and a narrow band (for ties) into full-width random values.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    int          near_zero;
    roll = $urandom_range(99);
    if (roll < 5) return MOST_NEGATIVE;
    if (roll < 10) return MOST_POSITIVE;
    if (roll < 35) begin
      near_zero = $urandom_range(6);
      return DATA_W'(near_zero - 3);
    end
    return {$urandom, $urandom};
  endfunction

  // Receiver: random ready, one long hold-off on request, no idling when steady.
  initial begin : result_sink
    int unsigned held;
    bit          hold_served;
    hold_served  = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_served) begin
        // Hold ready low while the sender keeps offering queries.
        for (held = 0; held < HOLD_CYCLES; held++) begin
          out_ch.ready <= 1'b0;
          @(negedge clk_i);
        end
        hold_served = 1'b1;
      end
      out_ch.ready <= steady || ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog: no word moved for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("range_maximum_sparse_table_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned set_index;
    int unsigned set_size;
    int unsigned n_queries;
    int unsigned lo;
    int unsigned hi;

    // Drive every input to a known value before reset.
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_LOAD;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    in_ch.left  = '0;
    in_ch.right = '0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Query before anything is loaded: error.
    ask_range(0, 0);
    // Load with all-ones range fields, then query before the build: error.
    push_word(CMD_LOAD, MOST_NEGATIVE, 1'b0, '1, '1);
    ask_range(0, 0);
    load_value(MOST_POSITIVE, 1'b0);
    load_value(DATA_W'(-1), 1'b0);
    load_value(DATA_W'(0), 1'b0);
    load_value(DATA_W'(1), 1'b1);      // five values, build
    ask_range(0, 4);                   // most positive
    ask_range(0, 0);                   // most negative
    ask_range(2, 3);
    ask_range(3, 2);                   // empty range: error
    ask_range(2, 5);                   // right past the data: error
    ask_range(1023, 1023);             // far out of range: error
    push_word(CMD_QUERY, MOST_POSITIVE, 1'b1, POS_W'(4), POS_W'(4));  // value and last ignored
    ask_range(2, 4);
    // Load after a build: a new single-value set.
    load_value(DATA_W'(7), 1'b1);
    ask_range(0, 0);
    ask_range(0, 1);                   // error
    // Ties across the whole range.
    load_value(DATA_W'(-5), 1'b0);
    load_value(DATA_W'(-5), 1'b0);
    load_value(DATA_W'(-5), 1'b1);
    ask_range(0, 2);

    // A mid-size set for the back-pressure test.
    for (int i = 0; i < PRESSURE_LOADS; i++) begin
      load_value(pick_value(), i == PRESSURE_LOADS - 1);
    end
    // Long receiver hold-off while queries keep coming, so the block backs up.
    hold_request = 1'b1;
    ask_range(0, PRESSURE_LOADS - 1);
    ask_range(PRESSURE_LOADS - 1, PRESSURE_LOADS - 1);
    ask_range(0, PRESSURE_LOADS / 2 - 1);
    ask_range(PRESSURE_LOADS / 2, PRESSURE_LOADS - 1);
    ask_range(1, PRESSURE_LOADS - 2);
    for (int i = 0; i < 25; i++) begin
      hi = $urandom_range(PRESSURE_LOADS - 1);
      lo = $urandom_range(hi);
      ask_range(lo, hi);
    end

    // Random part: mostly small data sets, each followed by a burst of queries.
    random_items = 0;
    set_index    = 0;
    while (random_items < RANDOM_ITEMS) begin
      steady = (set_index == 3);       // one long stretch with no idling
      if (steady) set_size = 64;
      else if ($urandom_range(9) == 0) set_size = $urandom_range(200, 33);
      else set_size = $urandom_range(32, 1);
      for (int i = 0; i < set_size; i++) begin
        // Stray query among the loads: error, unless it comes before the first load of the set.
        if ($urandom_range(19) == 0) begin
          ask_range($urandom_range(MAX_ELEMENTS - 1), $urandom_range(MAX_ELEMENTS - 1));
          random_items++;
        end
        load_value(pick_value(), i == set_size - 1);
        random_items++;
      end
      n_queries = steady ? 40 : $urandom_range(20, 4);
      for (int i = 0; i < n_queries; i++) begin
        if ($urandom_range(9) < 8) begin
          hi = $urandom_range(set_size - 1);
          lo = $urandom_range(hi);
        end else begin
          // Noise: any pair, mostly empty or out of range.
          hi = $urandom_range(MAX_ELEMENTS - 1);
          lo = $urandom_range(MAX_ELEMENTS - 1);
        end
        ask_range(lo, hi);
        random_items++;
      end
      set_index++;
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain: wait for every expected result, then keep watching for strays before the verdict.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d load words in %0d table builds, with a long receiver stall,",
             loads, builds);
    $display("and %0d query results, %0d of them flagged as errors.", results, flagged);
    if (mismatches == 0 && pending == 0) begin
      $display("range_maximum_sparse_table_unit verification clean");
    end else begin
      $display("range_maximum_sparse_table_unit verification failed");
    end
    $finish;
  end

endmodule
